### rtl/core/crlf_terminated_packet_receiver_defines.svh
// Assertion macros for the CRLF packet receiver.
// Expects clk and arst_n in the scope of use.
`ifndef CRLF_TERMINATED_PACKET_RECEIVER_DEFINES_SVH
`define CRLF_TERMINATED_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication
`define CRLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/crlf_pkg.sv
// Types and constants for the CRLF packet receiver.
// No dependencies.
package crlf_pkg;

	localparam int unsigned PACKET_BYTES = 64;

	typedef enum logic [1:0] {
		REQ_RX_BYTE = 2'd0,
		REQ_READ    = 2'd1,
		REQ_TAKE    = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_END2   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_HDR_A = 2'd0,
		REG_HDR_B = 2'd1,
		REG_END1  = 2'd2,
		REG_END2  = 2'd3
	} reg_idx_t;

	localparam logic [7:0] HDR_A_RST = 8'd115;
	localparam logic [7:0] HDR_B_RST = 8'd114;
	localparam logic [7:0] END1_RST  = 8'd13;
	localparam logic [7:0] END2_RST  = 8'd10;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [5:0] read_index;
	} crlf_in_t;

	typedef struct packed {
		logic       packet_ready;
		logic [5:0] packet_length;
		logic [7:0] read_data;
		logic       overflow;
	} crlf_out_t;

endpackage

### rtl/core/crlf_terminated_packet_receiver.sv
// Top level of the CRLF packet receiver: framer, packet store, host reads, APB registers.
// Depends on crlf_pkg and crlf_terminated_packet_receiver_defines.svh.
//
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, in_data              | sink
// out     | out_valid, out_ready, out_data           | source
// apb     | psel, penable, pwrite, paddr, pwdata,    | slave
//         | prdata, pready                           |
//
// One word per cycle while the output is not stalled; each result passes through stage 1
// (state and store read at acceptance, store read data registered), then the output register.
// Reset clears phase, write position, flags and pipeline valids; store is not cleared.
// A stalled output holds; one more word is taken into stage 1 before in_ready drops.
`include "crlf_terminated_packet_receiver_defines.svh"

module crlf_terminated_packet_receiver #(
	parameter int unsigned PACKET_BYTES = crlf_pkg::PACKET_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  crlf_pkg::crlf_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output crlf_pkg::crlf_out_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
	localparam int unsigned CW = (AW > 6) ? AW : 6;
	localparam logic [AW-1:0] LAST_POS = AW'(PACKET_BYTES - 1);

	// configuration
	logic [7:0] hdr_a_q, hdr_b_q, end1_q, end2_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_a_q <= crlf_pkg::HDR_A_RST;
			hdr_b_q <= crlf_pkg::HDR_B_RST;
			end1_q  <= crlf_pkg::END1_RST;
			end2_q  <= crlf_pkg::END2_RST;
		end else if (cfg_wr) begin
			unique case (crlf_pkg::reg_idx_t'(paddr[3:2]))
				crlf_pkg::REG_HDR_A: hdr_a_q <= pwdata[7:0];
				crlf_pkg::REG_HDR_B: hdr_b_q <= pwdata[7:0];
				crlf_pkg::REG_END1:  end1_q  <= pwdata[7:0];
				crlf_pkg::REG_END2:  end2_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (crlf_pkg::reg_idx_t'(paddr[3:2]))
			crlf_pkg::REG_HDR_A: prdata = {24'd0, hdr_a_q};
			crlf_pkg::REG_HDR_B: prdata = {24'd0, hdr_b_q};
			crlf_pkg::REG_END1:  prdata = {24'd0, end1_q};
			crlf_pkg::REG_END2:  prdata = {24'd0, end2_q};
			default:             prdata = 32'd0;
		endcase
	end

	// pipeline handshake
	logic s1_v_s1, s2_v_s2;
	logic s1_adv, in_acc;

	assign s1_adv   = s1_v_s1 & (~s2_v_s2 | out_ready);
	assign in_ready = ~s1_v_s1 | s1_adv;
	assign in_acc   = in_valid & in_ready;

	// framer state
	crlf_pkg::phase_t ph_q, ph_d;
	logic [AW-1:0]    wpos_q, wpos_d;
	logic             rdy_q, rdy_d;
	logic             ovf_q, ovf_d;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic             is_rx, is_hdr;

	assign is_rx  = crlf_pkg::req_type_t'(in_data.req_type) == crlf_pkg::REQ_RX_BYTE;
	assign is_hdr = ((in_data.rx_byte == hdr_a_q) | (in_data.rx_byte == hdr_b_q)) & ~rdy_q;

	// next state
	always_comb begin
		ph_d = ph_q;
		if (is_rx) begin
			unique case (ph_q)
				crlf_pkg::PH_DATA:
					if (in_data.rx_byte == end1_q) ph_d = crlf_pkg::PH_END2;
				crlf_pkg::PH_END2:
					if (in_data.rx_byte == end2_q) ph_d = crlf_pkg::PH_HEADER;
				default:
					if (is_hdr) ph_d = crlf_pkg::PH_DATA;
			endcase
		end
	end

	// outputs of the framer
	always_comb begin
		wpos_d  = wpos_q;
		rdy_d   = rdy_q;
		ovf_d   = ovf_q;
		wr_en   = 1'b0;
		wr_addr = wpos_q;
		unique case (crlf_pkg::req_type_t'(in_data.req_type))
			crlf_pkg::REQ_RX_BYTE: begin
				unique case (ph_q)
					crlf_pkg::PH_DATA: begin
						if (in_data.rx_byte != end1_q) begin
							if (wpos_q < LAST_POS) begin
								wr_en  = 1'b1;
								wpos_d = wpos_q + AW'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
					end
					crlf_pkg::PH_END2: begin
						if (in_data.rx_byte == end2_q) rdy_d = 1'b1;
					end
					default: begin
						if (is_hdr) begin
							wr_en   = 1'b1;
							wr_addr = '0;
							wpos_d  = AW'(1);
							ovf_d   = 1'b0;
						end
					end
				endcase
			end
			crlf_pkg::REQ_TAKE: rdy_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= crlf_pkg::PH_HEADER;
			wpos_q <= '0;
			rdy_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (in_acc) begin
			ph_q   <= ph_d;
			wpos_q <= wpos_d;
			rdy_q  <= rdy_d;
			ovf_q  <= ovf_d;
		end
	end

	// packet store
	logic [7:0]    store_mem [PACKET_BYTES];
	logic [CW-1:0] idx_ext, wpos_ext, wpos_d_ext;
	logic [AW-1:0] rd_addr;
	logic          rd_hit;

	assign idx_ext    = CW'(in_data.read_index);
	assign wpos_ext   = CW'(wpos_q);
	assign wpos_d_ext = CW'(wpos_d);
	assign rd_addr    = idx_ext[AW-1:0];
	assign rd_hit     = (crlf_pkg::req_type_t'(in_data.req_type) == crlf_pkg::REQ_READ)
		& (idx_ext < wpos_ext);

	logic [7:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (in_acc && wr_en) store_mem[wr_addr] <= in_data.rx_byte;
		if (in_acc) rd_data_s1 <= store_mem[rd_addr];
	end

	// stage 1
	logic       rdy_s1, ovf_s1, hit_s1;
	logic [5:0] len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v_s1 <= 1'b0;
		else if (in_ready) s1_v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rdy_s1 <= rdy_q;
			ovf_s1 <= ovf_d;
			hit_s1 <= rd_hit;
			len_s1 <= wpos_d_ext[5:0];
		end
	end

	// stage 2, output register
	crlf_pkg::crlf_out_t out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s2_v_s2 <= 1'b0;
		else if (~s2_v_s2 | out_ready) s2_v_s2 <= s1_v_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_s2.packet_ready  <= rdy_s1;
			out_s2.packet_length <= len_s1;
			out_s2.read_data     <= hit_s1 ? rd_data_s1 : 8'd0;
			out_s2.overflow      <= ovf_s1;
		end
	end

	assign out_valid = s2_v_s2;
	assign out_data  = out_s2;

	`CRLF_ASSERT_NOW(a_wpos_bound, 1'b1, wpos_q <= LAST_POS, "write position past last slot")
	`CRLF_ASSERT_NOW(a_ovf_full, ovf_q, wpos_q == LAST_POS, "overflow with room left")
	`CRLF_ASSERT_NOW(a_rdy_rise, $rose(rdy_q), ph_q == crlf_pkg::PH_HEADER, "ready set mid-packet")
	`CRLF_ASSERT_NEXT(a_pending_hold, rdy_q && ph_q == crlf_pkg::PH_HEADER, $stable(wpos_q), "header taken while pending")
	`CRLF_ASSERT_NOW(a_stall_full, !in_ready, s1_v_s1 && s2_v_s2 && !out_ready, "input stalled with room")

endmodule

### tb/sv/tb_crlf_terminated_packet_receiver.sv
// Self-checking testbench for crlf_terminated_packet_receiver: directed and random framed
// traffic with random stalls on both sides, results checked against an in-bench framer model.
// Depends on crlf_pkg and the receiver RTL.
module tb_crlf_terminated_packet_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 100000;
	localparam int unsigned PW = $clog2(crlf_pkg::PACKET_BYTES);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	crlf_pkg::crlf_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	crlf_pkg::crlf_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	crlf_terminated_packet_receiver u_dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// framer model state and register copies
	logic [7:0] cfg_hdr_a = crlf_pkg::HDR_A_RST;
	logic [7:0] cfg_hdr_b = crlf_pkg::HDR_B_RST;
	logic [7:0] cfg_end1 = crlf_pkg::END1_RST;
	logic [7:0] cfg_end2 = crlf_pkg::END2_RST;
	crlf_pkg::phase_t fr_phase = crlf_pkg::PH_HEADER;
	int unsigned wr_pos = 0;
	logic [7:0] pkt_mem [crlf_pkg::PACKET_BYTES];
	logic rdy_flag = 1'b0;
	logic ovf_flag = 1'b0;

	crlf_pkg::crlf_in_t link_q [$];
	crlf_pkg::crlf_out_t want_q [$];
	int errors = 0;
	int cycles = 0;
	int tx_gap_max = 5;
	int rx_gap_max = 5;
	int tx_wait = 0;
	int rx_wait = 0;
	int hold_left = 0;
	int results_seen = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic crlf_pkg::crlf_out_t frame_word(crlf_pkg::crlf_in_t w);
		crlf_pkg::crlf_out_t r;
		r = '0;
		r.packet_ready = rdy_flag;
		case (w.req_type)
			crlf_pkg::REQ_RX_BYTE: begin
				case (fr_phase)
					crlf_pkg::PH_DATA: begin
						if (w.rx_byte == cfg_end1) begin
							fr_phase = crlf_pkg::PH_END2;
						end else if (wr_pos < crlf_pkg::PACKET_BYTES - 1) begin
							pkt_mem[wr_pos[PW-1:0]] = w.rx_byte;
							wr_pos++;
						end else begin
							ovf_flag = 1'b1;
						end
					end
					crlf_pkg::PH_END2: begin
						if (w.rx_byte == cfg_end2) begin
							fr_phase = crlf_pkg::PH_HEADER;
							rdy_flag = 1'b1;
						end
					end
					default: begin
						if ((w.rx_byte == cfg_hdr_a || w.rx_byte == cfg_hdr_b) && !rdy_flag) begin
							fr_phase = crlf_pkg::PH_DATA;
							pkt_mem[0] = w.rx_byte;
							wr_pos = 1;
							ovf_flag = 1'b0;
						end
					end
				endcase
			end
			crlf_pkg::REQ_READ: begin
				if (w.read_index < wr_pos)
					r.read_data = pkt_mem[w.read_index];
			end
			crlf_pkg::REQ_TAKE: rdy_flag = 1'b0;
			default: ;
		endcase
		r.packet_length = wr_pos[5:0];
		r.overflow = ovf_flag;
		return r;
	endfunction

	function automatic void check_field(string fname, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, act_v);
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready)
				want_q.push_back(frame_word(in_data));
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					tx_wait <= tx_wait - 1;
					in_valid <= 1'b0;
				end else if (link_q.size() != 0) begin
					in_data <= link_q.pop_front();
					in_valid <= 1'b1;
					tx_wait <= $urandom_range(0, tx_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : result_check
		crlf_pkg::crlf_out_t exp_w;
		int unsigned w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (want_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %p", $time, out_data);
				end else begin
					exp_w = want_q.pop_front();
					check_field("packet_ready", 8'(exp_w.packet_ready),
						8'(out_data.packet_ready));
					check_field("packet_length", 8'(exp_w.packet_length),
						8'(out_data.packet_length));
					check_field("read_data", exp_w.read_data, out_data.read_data);
					check_field("overflow", 8'(exp_w.overflow), 8'(out_data.overflow));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				if (results_seen == 299 || results_seen == 699) begin
					hold_left <= 80;
					out_ready <= 1'b0;
				end else begin
					w = $urandom_range(0, rx_gap_max);
					rx_wait <= w;
					out_ready <= (w == 0);
				end
			end else if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
				out_ready <= (rx_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void send_word(logic [1:0] req, logic [7:0] b, logic [5:0] idx);
		link_q.push_back('{req_type: req, rx_byte: b, read_index: idx});
	endfunction

	function automatic void add_noise();
		repeat ($urandom_range(1, 6))
			send_word(2'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
	endfunction

	// mostly well-formed packet; sometimes truncated before the end characters
	function automatic void add_packet(bit long_one);
		int n;
		logic [7:0] b;
		if ($urandom_range(0, 3) != 0)
			send_word(crlf_pkg::REQ_TAKE, 8'($urandom), 6'($urandom));
		send_word(crlf_pkg::REQ_RX_BYTE, $urandom_range(0, 1) ? cfg_hdr_a : cfg_hdr_b,
			6'($urandom));
		n = long_one ? $urandom_range(60, 70) : $urandom_range(0, 12);
		repeat (n) begin
			b = 8'($urandom);
			if (b == cfg_end1)
				b = ~b;
			send_word(crlf_pkg::REQ_RX_BYTE, b, 6'($urandom));
			if ($urandom_range(0, 7) == 0)
				send_word(crlf_pkg::REQ_READ, 8'($urandom), 6'($urandom_range(0, n)));
		end
		if ($urandom_range(0, 9) == 0)
			return;
		send_word(crlf_pkg::REQ_RX_BYTE, cfg_end1, 6'($urandom));
		repeat ($urandom_range(0, 2)) begin
			b = 8'($urandom);
			if (b == cfg_end2)
				b = ~b;
			send_word(crlf_pkg::REQ_RX_BYTE, b, 6'($urandom));
		end
		send_word(crlf_pkg::REQ_RX_BYTE, cfg_end2, 6'($urandom));
		repeat ($urandom_range(1, 4))
			send_word(crlf_pkg::REQ_READ, 8'($urandom),
				($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, n + 1)));
		if ($urandom_range(0, 7) == 0)
			send_word(crlf_pkg::REQ_RX_BYTE, cfg_hdr_a, 6'($urandom));
	endfunction

	task automatic drain();
		do @(posedge clk); while (link_q.size() != 0 || in_valid || want_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(crlf_pkg::reg_idx_t idx, logic [7:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			crlf_pkg::REG_HDR_A: cfg_hdr_a = v;
			crlf_pkg::REG_HDR_B: cfg_hdr_b = v;
			crlf_pkg::REG_END1: cfg_end1 = v;
			default: cfg_end2 = v;
		endcase
	endtask

	// two halves, with a full drain after each
	task automatic run_phase(int n, int tx_max, int rx_max);
		tx_gap_max = tx_max;
		rx_gap_max = rx_max;
		add_packet(1'b1);
		repeat (2) begin
			while (link_q.size() < n / 2) begin
				if ($urandom_range(0, 4) == 0)
					add_noise();
				else
					add_packet($urandom_range(0, 15) == 0);
			end
			drain();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(crlf_pkg::REQ_READ, 8'h00, 6'd0);
		send_word(REQ_UNUSED, 8'hff, 6'h3f);
		send_word(crlf_pkg::REQ_TAKE, 8'h00, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, "a", 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::HDR_A_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::HDR_B_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::HDR_A_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, 8'h00, 6'h3f);
		send_word(crlf_pkg::REQ_RX_BYTE, 8'hff, 6'd0);
		send_word(crlf_pkg::REQ_READ, 8'h00, 6'd2);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::END1_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, "x", 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::END1_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::END2_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::HDR_B_RST, 6'd0);
		send_word(crlf_pkg::REQ_READ, 8'hff, 6'd0);
		send_word(crlf_pkg::REQ_READ, 8'h00, 6'd4);
		send_word(crlf_pkg::REQ_READ, 8'h00, 6'd5);
		send_word(crlf_pkg::REQ_READ, 8'h00, 6'h3f);
		send_word(crlf_pkg::REQ_TAKE, 8'h00, 6'd0);
		send_word(crlf_pkg::REQ_TAKE, 8'hff, 6'h3f);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::HDR_B_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::END1_RST, 6'd0);
		send_word(crlf_pkg::REQ_RX_BYTE, crlf_pkg::END2_RST, 6'd0);
		send_word(crlf_pkg::REQ_TAKE, 8'h00, 6'd0);
		drain();
		run_phase(230, 5, 5);

		reg_write(crlf_pkg::REG_HDR_A, 8'h00);
		reg_write(crlf_pkg::REG_HDR_B, 8'hff);
		reg_write(crlf_pkg::REG_END1, 8'hff);
		reg_write(crlf_pkg::REG_END2, 8'h00);
		run_phase(230, 0, 0);

		reg_write(crlf_pkg::REG_HDR_A, 8'($urandom));
		reg_write(crlf_pkg::REG_HDR_B, 8'($urandom));
		reg_write(crlf_pkg::REG_END1, 8'($urandom));
		reg_write(crlf_pkg::REG_END2, 8'($urandom));
		run_phase(230, 0, 5);

		reg_write(crlf_pkg::REG_HDR_A, 8'hff);
		reg_write(crlf_pkg::REG_HDR_B, 8'hff);
		reg_write(crlf_pkg::REG_END1, 8'h00);
		reg_write(crlf_pkg::REG_END2, 8'hff);
		run_phase(230, 5, 0);

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
